[design/fxexp2_pkg.sv]
// shared constants, types and constant functions of the shift-add exp2 unit
package fxexp2_pkg;

	localparam int WIDTH_DEF     = 32;
	localparam int FRAC_BITS_DEF = 20;
	localparam int MAX_ITER_DEF  = 20;

	localparam int X_W        = 32;
	localparam int Y_W        = 32;
	localparam int KIND_W     = 2;
	localparam int ITER_CFG_W = 6;
	localparam logic [ITER_CFG_W-1:0] ITER_RESET = 6'd20;

	// log2(e) and log2(10) with 32 fraction bits
	localparam logic [63:0] LOG2E_Q32   = 64'h0000_0001_7154_7653;
	localparam logic [63:0] LOG2_10_Q32 = 64'h0000_0003_5269_E12F;
	localparam int LOG_BITS = 44;

	typedef enum logic [KIND_W-1:0] {
		KIND_EXP2  = 2'd0,
		KIND_EXP   = 2'd1,
		KIND_EXP10 = 2'd2,
		KIND_EXPM1 = 2'd3
	} kind_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic split;
		logic step;
		logic finish;
	} dp_cmd_t;

	// log2(1 + 2^-idx) rounded to nearest at fb fraction bits, by repeated squaring
	function automatic logic [63:0] log2_entry(input int unsigned idx, input int unsigned fb);
		logic [63:0]  m;
		logic [63:0]  l;
		logic [127:0] p;
		if (idx == 0) begin
			return 64'd0;
		end
		m = (64'd1 << 62) + (64'd1 << (62 - idx));
		l = 64'd0;
		for (int k = 0; k < LOG_BITS; k++) begin
			p = {64'd0, m} * {64'd0, m};
			m = p[125:62];
			l = l << 1;
			if (m[63]) begin
				l[0] = 1'b1;
				m = m >> 1;
			end
		end
		return (l + (64'd1 << (LOG_BITS - 1 - fb))) >> (LOG_BITS - fb);
	endfunction

	// 32-fraction-bit constant rounded to nearest at fb fraction bits
	function automatic logic [63:0] const_round(input logic [63:0] c32, input int unsigned fb);
		return (c32 + (64'd1 << (31 - fb))) >> (32 - fb);
	endfunction

endpackage

[design/fxexp2_ctrl.sv]
// sequencing state machine of the shift-add exp2 unit
module fxexp2_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 core_done,
	output fxexp2_pkg::dp_cmd_t  cmd,
	output logic                 busy,
	output logic                 done
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SPLIT,
		ST_CORE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.mul    = (state_q == ST_MUL);
		cmd.split  = (state_q == ST_SPLIT);
		cmd.step   = (state_q == ST_CORE) && !core_done;
		cmd.finish = (state_q == ST_FINISH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_MUL;
						busy_q  <= 1'b1;
					end
				end
				ST_MUL: begin
					state_q <= ST_SPLIT;
				end
				ST_SPLIT: begin
					state_q <= ST_CORE;
				end
				ST_CORE: begin
					if (core_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

[design/fxexp2_dp.sv]
// datapath of the shift-add exp2 unit: scaling multiply, split, shift-add core, output shift
module fxexp2_dp #(
	parameter int WIDTH     = fxexp2_pkg::WIDTH_DEF,
	parameter int FRAC_BITS = fxexp2_pkg::FRAC_BITS_DEF,
	parameter int MAX_ITER  = fxexp2_pkg::MAX_ITER_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fxexp2_pkg::dp_cmd_t                  cmd,
	output logic                                 core_done,
	input  logic                                 cfg_we,
	input  logic [fxexp2_pkg::ITER_CFG_W-1:0]    cfg_data,
	input  logic [fxexp2_pkg::KIND_W-1:0]        kind,
	input  logic signed [fxexp2_pkg::X_W-1:0]    x,
	output logic signed [fxexp2_pkg::Y_W-1:0]    y
);

	localparam int CFG_W = fxexp2_pkg::ITER_CFG_W;
	localparam int XW    = fxexp2_pkg::X_W;
	localparam int YW    = fxexp2_pkg::Y_W;
	localparam int BW    = 66;
	localparam int XSW   = (WIDTH < XW) ? WIDTH : XW;
	localparam int CB    = FRAC_BITS + 2;
	localparam int PW    = XSW + CB + 1;
	localparam int EW    = (WIDTH > FRAC_BITS + 2) ? WIDTH : FRAC_BITS + 2;
	localparam int CW    = (WIDTH - 1 > FRAC_BITS) ? WIDTH - 1 : FRAC_BITS;
	localparam int IW    = $clog2(MAX_ITER + 1);
	localparam int TIW   = $clog2(MAX_ITER);
	localparam int TAB_N = 1 << TIW;
	localparam int SW    = $clog2(FRAC_BITS);
	localparam int OW    = (EW > YW) ? EW : YW;

	localparam logic signed [BW-1:0] SMAX = (66'sd1 <<< (WIDTH - 1)) - 66'sd1;
	localparam logic signed [BW-1:0] SMIN = -SMAX - 66'sd1;
	// below this the floor exponent is at or under minus FRAC_BITS
	localparam logic signed [BW-1:0] ZLIM =
		66'sd0 - ((66'sd1 <<< FRAC_BITS) * BW'(FRAC_BITS - 1));
	localparam logic [EW-1:0] MAXV = (EW'(1) << (WIDTH - 1)) - EW'(1);
	localparam logic [EW-1:0] ONE_E = EW'(1) << FRAC_BITS;
	localparam logic [OW-1:0] ONE_O = OW'(1) << FRAC_BITS;
	localparam logic [CFG_W-1:0] MAX_ITER_C = CFG_W'(MAX_ITER);

	localparam logic [63:0] C_E_FULL  =
		fxexp2_pkg::const_round(fxexp2_pkg::LOG2E_Q32, FRAC_BITS);
	localparam logic [63:0] C_10_FULL =
		fxexp2_pkg::const_round(fxexp2_pkg::LOG2_10_Q32, FRAC_BITS);
	localparam logic [CB-1:0] C_E  = C_E_FULL[CB-1:0];
	localparam logic [CB-1:0] C_10 = C_10_FULL[CB-1:0];

	// log2(1 + 2^-i) table, entry 0 and entries past MAX_ITER unused
	logic [FRAC_BITS-1:0] tab [TAB_N];

	for (genvar g = 0; g < TAB_N; g++) begin : g_tab
		localparam logic [63:0] ENT = (g < MAX_ITER) ?
			fxexp2_pkg::log2_entry(g, FRAC_BITS) : 64'd0;
		assign tab[g] = ENT[FRAC_BITS-1:0];
	end

	logic [CFG_W-1:0]            it_q;
	fxexp2_pkg::kind_t           kind_q;
	logic signed [XSW-1:0]       xs_q;
	logic [IW-1:0]               n_q;
	logic signed [PW-1:0]        prod_q;
	logic [CW-1:0]               r_q;
	logic [EW-1:0]               en_q;
	logic [IW-1:0]               i_q;
	logic                        sat_q;
	logic                        zero_q;
	logic [SW-1:0]               shift_q;
	logic [YW-1:0]               y_q;

	logic signed [BW-1:0]  x_w;
	logic signed [BW-1:0]  x_sat;
	logic [IW-1:0]         n_sel;
	logic [CB-1:0]         c_sel;
	logic signed [BW-1:0]  q_w;
	logic signed [BW-1:0]  q_sat;
	logic signed [BW-1:0]  t_w;
	logic signed [BW-1:0]  b_w;
	logic signed [BW-1:0]  negb_w;
	logic                  t_neg;
	logic                  t_zero;
	logic [CW-1:0]         r_init;
	logic [CW-1:0]         a_ext;
	logic                  take;
	logic [EW-1:0]         en_add;
	logic [OW-1:0]         y_full;

	// operand into the working range, iteration count clamped, scaling constant picked
	always_comb begin
		x_w   = BW'(x);
		x_sat = (x_w > SMAX) ? SMAX : ((x_w < SMIN) ? SMIN : x_w);
		n_sel = (it_q > MAX_ITER_C) ? MAX_ITER_C[IW-1:0] : it_q[IW-1:0];
		c_sel = (kind_q == fxexp2_pkg::KIND_EXP10) ? C_10 : C_E;
	end

	// floored scaled operand (exp2: raw operand), saturated, split into exponent and fraction
	always_comb begin
		q_w    = BW'(prod_q) >>> FRAC_BITS;
		q_sat  = (q_w > SMAX) ? SMAX : ((q_w < SMIN) ? SMIN : q_w);
		t_w    = (kind_q == fxexp2_pkg::KIND_EXP2) ? BW'(xs_q) : q_sat;
		t_neg  = t_w[BW-1];
		t_zero = (t_w < ZLIM);
		b_w    = t_w >>> FRAC_BITS;
		negb_w = -b_w;
		r_init = t_neg ? CW'(t_w[FRAC_BITS-1:0]) : t_w[CW-1:0];
	end

	// one shift-add step
	always_comb begin
		a_ext  = CW'(tab[i_q[TIW-1:0]]);
		take   = (a_ext != '0) && (a_ext <= r_q);
		en_add = en_q + (en_q >> i_q);
	end

	assign core_done = zero_q || sat_q || (i_q >= n_q);

	always_comb begin
		y_full = zero_q ? '0 : OW'(en_q >> shift_q);
		if (kind_q == fxexp2_pkg::KIND_EXPM1) begin
			y_full = y_full - ONE_O;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q <= fxexp2_pkg::ITER_RESET;
		end else if (cfg_we) begin
			it_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= fxexp2_pkg::kind_t'(kind);
			xs_q   <= x_sat[XSW-1:0];
			n_q    <= n_sel;
		end
		if (cmd.mul) begin
			prod_q <= xs_q * $signed({1'b0, c_sel});
		end
		if (cmd.split) begin
			zero_q  <= t_neg && t_zero;
			shift_q <= (t_neg && !t_zero) ? negb_w[SW-1:0] : '0;
			r_q     <= r_init;
			en_q    <= ONE_E;
			i_q     <= IW'(1);
			sat_q   <= 1'b0;
		end
		if (cmd.step) begin
			if (take) begin
				r_q <= r_q - a_ext;
				if (en_add >= MAXV) begin
					en_q  <= MAXV;
					sat_q <= 1'b1;
				end else begin
					en_q <= en_add;
				end
			end else begin
				i_q <= i_q + IW'(1);
			end
		end
		if (cmd.finish) begin
			y_q <= y_full[YW-1:0];
		end
	end

	assign y = y_q;

endmodule

[design/fixed_point_exp2_shift_add_unit.sv]
// top level of the shift-add fixed-point exp2 / e^x / 10^x / e^x-1 unit
//
// a request is taken at a clock edge where start is high and busy is low; the
// result appears on y for exactly one cycle with done high and cannot be held
// off, so capture it when done is seen. busy stays high from the edge that
// takes the request until the edge that raises done, and a new request can be
// given in the cycle where done is high. the operand is loaded at the edge
// that takes the request; then the scaling multiply by log2(e) or log2(10)
// runs, the operand is split into exponent and fraction, the shift-add core
// runs, the estimate is shifted into y, and y is shown with done high.
// the core does one table step per cycle with its add/compare logic: each
// table entry (n - 1 entries, n being the iterations register clamped to
// MAX_ITER) is stepped again after each accepted addition and left after a
// rejected one, and the walk ends early when the estimate saturates; an
// operand that underflows to zero skips the walk. iterations is written
// through cfg_we / cfg_data and must only change while busy is low
module fixed_point_exp2_shift_add_unit #(
	parameter int WIDTH     = fxexp2_pkg::WIDTH_DEF,
	parameter int FRAC_BITS = fxexp2_pkg::FRAC_BITS_DEF,
	parameter int MAX_ITER  = fxexp2_pkg::MAX_ITER_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request side
	input  logic                                 start,
	output logic                                 busy,
	input  logic [fxexp2_pkg::KIND_W-1:0]        kind,
	input  logic signed [fxexp2_pkg::X_W-1:0]    x,
	// result side, one-cycle strobe
	output logic                                 done,
	output logic signed [fxexp2_pkg::Y_W-1:0]    y,
	// iteration count register
	input  logic                                 cfg_we,
	input  logic [fxexp2_pkg::ITER_CFG_W-1:0]    cfg_data
);

	fxexp2_pkg::dp_cmd_t cmd;
	logic                core_done;

	// sequencer: walks load, multiply, split, core steps and output
	fxexp2_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.core_done (core_done),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	// arithmetic: scaling multiplier, table walk, shifters
	fxexp2_dp #(
		.WIDTH     (WIDTH),
		.FRAC_BITS (FRAC_BITS),
		.MAX_ITER  (MAX_ITER)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.core_done (core_done),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.kind      (kind),
		.x         (x),
		.y         (y)
	);

endmodule

[design/fxexp2_chk.sv]
// port-level checks of the shift-add exp2 unit, bound to the top level
module fxexp2_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// result strobe never overlaps work in progress
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// a taken request makes the unit busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken but not busy");

	// no result sooner than the fixed load, multiply and split cycles
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (!done ##1 !done ##1 !done))
		else $error("result too early");

	// busy ends only together with a result
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without result");

	// one strobe per request
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done longer than one cycle");

endmodule

bind fixed_point_exp2_shift_add_unit fxexp2_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

[bench/fixed_point_exp2_shift_add_unit_test.sv]
// self-checking bench of the shift-add exp2 / e^x / 10^x / e^x-1 unit
`timescale 1ns / 1ps

import fxexp2_pkg::*;

typedef struct {
	kind_t              kind;
	logic signed [31:0] x;
	logic signed [31:0] y;
} exp2_expect_t;

class exp2_scoreboard;
	localparam int     WIDTH     = WIDTH_DEF;
	localparam int     FRAC_BITS = FRAC_BITS_DEF;
	localparam int     MAX_ITER  = MAX_ITER_DEF;
	localparam int     LOG_LEN   = 33;
	localparam longint ONE       = longint'(1) << FRAC_BITS;
	localparam longint SAT_HI    = (longint'(1) << (WIDTH - 1)) - 1;
	localparam longint SAT_LO    = -SAT_HI - 1;
	localparam longint C_LOG2E   =
		longint'((LOG2E_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));
	localparam longint C_LOG2_10 =
		longint'((LOG2_10_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS));

	longint              log_tab [LOG_LEN];
	logic [5:0]          iter_reg;
	exp2_expect_t        awaited_results [$];
	int                  errors;

	function new();
		bit [63:0]  m;
		bit [63:0]  l;
		bit [127:0] sq;
		iter_reg = ITER_RESET;
		errors = 0;
		log_tab[0] = ONE;
		// log2(1 + 2^-i) by repeated squaring, one result bit per squaring
		for (int i = 1; i < LOG_LEN; i++) begin
			m = (64'd1 << 62) + (64'd1 << (62 - i));
			l = 64'd0;
			repeat (LOG_BITS) begin
				sq = {64'd0, m} * {64'd0, m};
				m = sq[125:62];
				l = l << 1;
				if (m[63]) begin
					l[0] = 1'b1;
					m = m >> 1;
				end
			end
			log_tab[i] = longint'((l + (64'd1 << (LOG_BITS - 1 - FRAC_BITS)))
				>> (LOG_BITS - FRAC_BITS));
		end
	endfunction

	function longint clamp_w(longint v);
		if (v > SAT_HI) return SAT_HI;
		if (v < SAT_LO) return SAT_LO;
		return v;
	endfunction

	function longint shift_add_core(longint r, int n);
		longint est;
		longint a;
		est = ONE;
		for (int i = 1; i < n && i < LOG_LEN; i++) begin
			a = log_tab[i];
			if (a == 0) continue;
			while (a <= r) begin
				r -= a;
				est += est >> i;
				if (est >= SAT_HI) return SAT_HI;
			end
		end
		return est;
	endfunction

	function logic signed [31:0] exp_of_operand(kind_t k, logic signed [31:0] xv);
		longint xs;
		longint t;
		longint b;
		longint res;
		int     n;
		logic signed [31:0] y_out;
		n = (iter_reg > MAX_ITER) ? MAX_ITER : int'(iter_reg);
		xs = clamp_w(longint'(xv));
		case (k)
			KIND_EXP, KIND_EXPM1: t = clamp_w((xs * C_LOG2E) >>> FRAC_BITS);
			KIND_EXP10:           t = clamp_w((xs * C_LOG2_10) >>> FRAC_BITS);
			default:              t = xs;
		endcase
		if (t >= 0) begin
			res = shift_add_core(t, n);
		end else begin
			b = t >>> FRAC_BITS;
			if (b <= -FRAC_BITS) res = 0;
			else res = shift_add_core(t & (ONE - 1), n) >> (-b);
		end
		if (k == KIND_EXPM1) res -= ONE;
		y_out = res[31:0];
		return y_out;
	endfunction

	function void note_request(kind_t k, logic signed [31:0] xv);
		exp2_expect_t e;
		e.kind = k;
		e.x = xv;
		e.y = exp_of_operand(k, xv);
		awaited_results.push_back(e);
	endfunction

	function void check_result(logic signed [31:0] got);
		exp2_expect_t e;
		if (awaited_results.size() == 0) begin
			$display("%0t: unexpected result y %h, none expected", $time, got);
			errors++;
			return;
		end
		e = awaited_results.pop_front();
		if (got !== e.y) begin
			$display("%0t: y mismatch, kind %s x %h: expected %h actual %h",
				$time, e.kind.name(), e.x, e.y, got);
			errors++;
		end
	endfunction
endclass

module fixed_point_exp2_shift_add_unit_test;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_ITEMS    = 205;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               start    = 1'b0;
	logic [KIND_W-1:0]  kind     = '0;
	logic signed [31:0] x        = '0;
	logic               cfg_we   = 1'b0;
	logic [5:0]         cfg_data = '0;
	logic               busy;
	logic               done;
	logic signed [31:0] y;

	exp2_scoreboard sb;
	int             idle_pct = 23;
	int             stall_cycles = 0;

	fixed_point_exp2_shift_add_unit #(
		.WIDTH     (WIDTH_DEF),
		.FRAC_BITS (FRAC_BITS_DEF),
		.MAX_ITER  (MAX_ITER_DEF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.kind     (kind),
		.x        (x),
		.done     (done),
		.y        (y),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// 4 ns period
	always #2 clk = ~clk;

	// results are strobed for one cycle, so take them on every edge that sees done
	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(y);
	end

	// cycles with neither a request nor a result taken
	always @(posedge clk) begin
		if ((start && !busy) || done) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// most operands sit where the integer part neither underflows nor saturates
	function automatic logic signed [31:0] pick_operand(kind_t k);
		int unsigned sel;
		int          v;
		sel = $urandom_range(99);
		if (sel < 55) v = int'($urandom_range(0, 34 << 20)) - (22 << 20);
		// integer boundaries, one lsb either side
		else if (sel < 70) v = ((int'($urandom_range(0, 33)) - 21) <<< 20)
			+ int'($urandom_range(0, 2)) - 1;
		else if (sel < 80) v = int'($urandom_range(0, 8191)) - 4096;
		else v = int'($urandom());
		// 10^x scales by about 3.3, so pull the window in
		if (k == KIND_EXP10 && sel < 70) v = v / 3;
		return v;
	endfunction

	// one request: optional idle gap, then hold start until the unit takes it
	task automatic issue(kind_t k, logic signed [31:0] v);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 60)) @(posedge clk);
		end
		start <= 1'b1;
		kind  <= k;
		x     <= v;
		do @(posedge clk); while (busy);
		sb.note_request(k, v);
	endtask

	// stop requesting and wait until every result is back and the unit is idle
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (busy || sb.awaited_results.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	// iterations may only change while the unit is idle
	task automatic write_iterations(logic [5:0] v);
		drain();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.iter_reg = v;
	endtask

	initial begin
		logic [5:0] phase_iters [9];
		sb = new();
		phase_iters = '{6'd32, 6'd2, 6'd63, 6'd20, 6'd0, 6'd17, 6'd0, 6'd1, 6'd0};
		// three of the phases get a random count
		phase_iters[4] = 6'($urandom_range(0, 63));
		phase_iters[6] = 6'($urandom_range(0, 63));
		phase_iters[8] = 6'($urandom_range(0, 63));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero and both extremes for every kind, at the reset count
		for (int k = 0; k < 4; k++) begin
			issue(kind_t'(k), 32'sd0);
			issue(kind_t'(k), 32'sh7FFF_FFFF);
			issue(kind_t'(k), 32'sh8000_0000);
		end
		// smallest shift that still leaves a nonzero result, and the step below it
		issue(KIND_EXP2, -(19 <<< 20));
		issue(KIND_EXP2, -(19 <<< 20) - 1);
		issue(KIND_EXP2, -(20 <<< 20));
		issue(KIND_EXP2, -1);
		// just under the estimate saturation point
		issue(KIND_EXP2, 32'sh00AF_FFFF);
		issue(KIND_EXP10, 3 <<< 20);
		issue(KIND_EXPM1, 32'sh0000_0800);
		// too few iterations, the core stays at one
		write_iterations(6'd1);
		issue(KIND_EXP2, 5 <<< 20);
		issue(KIND_EXPM1, -(3 <<< 20));
		write_iterations(6'd0);
		issue(KIND_EXP, 2 <<< 20);
		issue(KIND_EXP2, 32'sh7FFF_FFFF);

		// random phases, one iteration count each, the third without idling
		for (int p = 0; p < 9; p++) begin
			write_iterations(phase_iters[p]);
			idle_pct = (p == 2) ? 0 : 23;
			repeat (PHASE_ITEMS) begin
				kind_t k;
				k = kind_t'($urandom_range(0, 3));
				issue(k, pick_operand(k));
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
design/fxexp2_pkg.sv
design/fxexp2_ctrl.sv
design/fxexp2_dp.sv
design/fixed_point_exp2_shift_add_unit.sv
design/fxexp2_chk.sv
bench/fixed_point_exp2_shift_add_unit_test.sv
